FILE: hw/rtl/kcac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code alarm controller package
// Shared constants, mode encoding and item types for the keypad code alarm.
// ----------------------------------------------------------------------------
package kcac_pkg;

  localparam int unsigned CODE_DIGITS_DEF = 4;
  localparam int unsigned DIST_W          = 9;
  localparam int unsigned CHAR_W          = 8;

  localparam logic [CHAR_W-1:0] KEY_NONE   = 8'h00;
  localparam logic [CHAR_W-1:0] KEY_ARM    = 8'h2A;
  localparam logic [CHAR_W-1:0] KEY_CHANGE = 8'h23;
  localparam logic [CHAR_W-1:0] KEY_ZERO   = 8'h30;

  localparam logic [DIST_W-1:0] ALARM_DIST_RST = 9'd20;

  typedef enum logic {
    EV_KEY    = 1'b0,
    EV_SAMPLE = 1'b1
  } event_e;

  typedef enum logic [1:0] {
    MODE_ARMED    = 2'd0,
    MODE_DISARMED = 2'd1,
    MODE_CHANGE   = 2'd2
  } lock_mode_e;

  typedef struct packed {
    logic              mode;
    logic [CHAR_W-1:0] key_char;
    logic [DIST_W-1:0] distance_cm;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        mode_state;
    logic              alarm_on;
    logic [1:0]        digits_entered;
    logic              code_accepted;
    logic              code_rejected;
    logic              code_changed;
    logic              echo_key;
    logic [CHAR_W-1:0] key_shown;
  } out_item_t;

  typedef logic [DIST_W-1:0] cfg_word_t;

endpackage

FILE: hw/rtl/kcac_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code alarm stream interface
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface kcac_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (
    output valid,
    output data,
    input  ready
  );

  modport sink (
    input  valid,
    input  data,
    output ready
  );

endinterface

FILE: hw/rtl/kcac_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code alarm input stage
// Registers each accepted item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module kcac_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  kcac_pkg::in_item_t item_i,
  input  logic               advance_i,
  output logic               ready_o,
  output logic               valid_o,
  output kcac_pkg::in_item_t item_o
);

  logic               valid_q, valid_d;
  kcac_pkg::in_item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: hw/rtl/kcac_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code alarm core
// Holds the lock state, applies one registered item per cycle while advance_i
// is high, and registers the result item.
// ----------------------------------------------------------------------------
module kcac_core #(
  parameter int unsigned CODE_DIGITS = kcac_pkg::CODE_DIGITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  kcac_pkg::in_item_t  item_i,
  input  logic                advance_i,
  input  kcac_pkg::cfg_word_t alarm_distance_i,
  output logic                valid_o,
  output kcac_pkg::out_item_t result_o
);

  localparam int unsigned IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CODE_DIGITS - 1);

  logic [kcac_pkg::CHAR_W-1:0] stored_q [CODE_DIGITS];
  logic [kcac_pkg::CHAR_W-1:0] stored_d [CODE_DIGITS];
  logic [kcac_pkg::CHAR_W-1:0] entry_q  [CODE_DIGITS];
  logic [IDX_W-1:0]            idx_q, idx_d;
  kcac_pkg::lock_mode_e        mode_q, mode_d;
  logic                        alarm_q, alarm_d;
  logic                        res_valid_q, res_valid_d;
  kcac_pkg::out_item_t         res_q, res_d;

  logic                        fire;
  logic                        entry_wr;
  logic                        last_digit;
  logic                        match;
  logic                        accepted, rejected, changed, echo;
  logic [IDX_W+1:0]            idx_ext;
  logic [kcac_pkg::CHAR_W-1:0] key;

  assign fire       = valid_i && advance_i;
  assign key        = item_i.key_char;
  assign last_digit = (idx_q == IDX_LAST);

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (i == CODE_DIGITS - 1) begin
        stored_d[i] = key;
      end else begin
        stored_d[i] = entry_q[i];
      end
      match = match && (stored_d[i] == stored_q[i]);
    end
  end

  always_comb begin
    idx_d    = idx_q;
    mode_d   = mode_q;
    alarm_d  = alarm_q;
    entry_wr = 1'b0;
    accepted = 1'b0;
    rejected = 1'b0;
    changed  = 1'b0;
    echo     = 1'b0;
    if (item_i.mode == kcac_pkg::EV_SAMPLE) begin
      if (mode_q == kcac_pkg::MODE_ARMED && item_i.distance_cm <= alarm_distance_i) begin
        alarm_d = 1'b1;
      end
    end else if (key != kcac_pkg::KEY_NONE) begin
      unique case (mode_q)
        kcac_pkg::MODE_ARMED, kcac_pkg::MODE_CHANGE: begin
          entry_wr = 1'b1;
          echo     = 1'b1;
          if (last_digit) begin
            idx_d = '0;
            if (mode_q == kcac_pkg::MODE_ARMED) begin
              if (match) begin
                accepted = 1'b1;
                alarm_d  = 1'b0;
                mode_d   = kcac_pkg::MODE_DISARMED;
              end else begin
                rejected = 1'b1;
              end
            end else begin
              changed = 1'b1;
              mode_d  = kcac_pkg::MODE_ARMED;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        default: begin
          alarm_d = 1'b0;
          if (key == kcac_pkg::KEY_ARM) begin
            idx_d  = '0;
            mode_d = kcac_pkg::MODE_ARMED;
          end else if (key == kcac_pkg::KEY_CHANGE) begin
            idx_d  = '0;
            mode_d = kcac_pkg::MODE_CHANGE;
          end
        end
      endcase
    end
  end

  always_comb begin
    idx_ext              = (IDX_W+2)'(idx_d);
    res_d.mode_state     = mode_d;
    res_d.alarm_on       = alarm_d;
    res_d.digits_entered = idx_ext[1:0];
    res_d.code_accepted  = accepted;
    res_d.code_rejected  = rejected;
    res_d.code_changed   = changed;
    res_d.echo_key       = echo;
    res_d.key_shown      = echo ? key : kcac_pkg::KEY_NONE;
  end

  assign res_valid_d = advance_i ? valid_i : res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      mode_q      <= kcac_pkg::MODE_ARMED;
      alarm_q     <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        stored_q[i] <= kcac_pkg::KEY_ZERO;
      end
    end else begin
      res_valid_q <= res_valid_d;
      if (fire) begin
        idx_q   <= idx_d;
        mode_q  <= mode_d;
        alarm_q <= alarm_d;
        if (changed) begin
          stored_q <= stored_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && entry_wr) begin
      entry_q[idx_q] <= key;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = res_valid_q;
  assign result_o = res_q;

endmodule

FILE: hw/rtl/keypad_code_alarm_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code alarm controller
// Code lock with a sticky distance alarm, one result item per input item.
// ----------------------------------------------------------------------------
// Usage: item_i carries key presses and distance samples, result_o returns
// one result item for each of them in order, and cfg_i writes the alarm
// distance threshold. All three are valid/ready channels; cfg_i is always
// ready and should be written only while no item is in flight.
// An item is registered in the input stage, then the core applies it to the
// lock state and registers its result in the result register. The state
// update is a single compare-and-update path, so while result_o is not
// stalled one item is accepted every cycle, a sustained rate of one per cycle.
// When the receiver stalls, the result register holds, and item_i ready stays
// high only while the input stage is empty.
// Reset clears both stages, arms the lock, clears the alarm and digit count,
// sets the stored code to all '0' characters and the threshold to 20 cm.
// ----------------------------------------------------------------------------
module keypad_code_alarm_controller #(
  parameter int unsigned CODE_DIGITS = kcac_pkg::CODE_DIGITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  kcac_stream_if.sink   item_i,
  kcac_stream_if.source result_o,
  kcac_stream_if.sink   cfg_i
);

  kcac_pkg::cfg_word_t alarm_distance_q;
  logic                advance;
  logic                s1_valid;
  kcac_pkg::in_item_t  s1_item;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_distance_q <= kcac_pkg::ALARM_DIST_RST;
    end else if (cfg_i.valid) begin
      alarm_distance_q <= cfg_i.data;
    end
  end

  assign advance = !result_o.valid || result_o.ready;

  kcac_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (item_i.valid),
    .item_i    (item_i.data),
    .advance_i (advance),
    .ready_o   (item_i.ready),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  kcac_core #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (s1_valid),
    .item_i           (s1_item),
    .advance_i        (advance),
    .alarm_distance_i (alarm_distance_q),
    .valid_o          (result_o.valid),
    .result_o         (result_o.data)
  );

  a_single_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> $onehot0({result_o.data.code_accepted,
                                 result_o.data.code_rejected,
                                 result_o.data.code_changed}))
    else $error("More than one code outcome in one result item.");

  a_accept_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.data.code_accepted) |->
      (result_o.data.mode_state == kcac_pkg::MODE_DISARMED &&
       !result_o.data.alarm_on && result_o.data.digits_entered == 2'd0))
    else $error("Accepted code did not disarm and clear the alarm.");

  a_change_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.data.code_changed) |->
      (result_o.data.mode_state == kcac_pkg::MODE_ARMED &&
       result_o.data.digits_entered == 2'd0))
    else $error("Code change did not rearm the lock.");

  a_outcome_needs_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.data.echo_key) |->
      (result_o.data.key_shown == kcac_pkg::KEY_NONE &&
       !result_o.data.code_accepted && !result_o.data.code_rejected &&
       !result_o.data.code_changed))
    else $error("Code outcome or shown key without an echoed key.");

  a_item_reaches_core: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> s1_valid)
    else $error("Accepted item was lost before the core.");

endmodule
